>>> design/dpf_pkg.sv
// Shared constants for the distinct prime factor block.
package dpf_pkg;

    // Width of the value and factor fields on the ports
    localparam int FIELD_WIDTH  = 32;
    // Trial division starts at the first prime, then steps to the odd numbers
    localparam int FIRST_PRIME  = 2;
    localparam int SECOND_PRIME = 3;

    // Control and result of one divider run
    typedef struct packed {
        logic start;
    } t_div_req;

    typedef struct packed {
        logic done;
        logic zero_rem;
    } t_div_stat;

endpackage

>>> design/dpf_div.sv
// Iterative restoring divider: one quotient bit per cycle, shared by all trial divisions.
module dpf_div #(
    parameter int NW = 32,
    parameter int DW = 18
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  dpf_pkg::t_div_req  i_req,
    input  logic [NW-1:0]      i_dividend,
    input  logic [DW-1:0]      i_divisor,
    output dpf_pkg::t_div_stat o_stat,
    output logic [NW-1:0]      o_quotient
);

    localparam int CW = $clog2(NW + 1);

    logic [DW-1:0] r_rem;
    logic [NW-1:0] r_quo;
    logic [DW-1:0] r_dsr;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;

    logic [DW:0]   n_shift;
    logic          n_bit;
    logic [DW-1:0] n_rem;
    logic [NW-1:0] n_quo;

    // One restoring step: shift in the next dividend bit, subtract if it fits
    always_comb begin
        n_shift = {r_rem, r_quo[NW-1]};
        n_bit   = (n_shift >= {1'b0, r_dsr});
        if (n_bit) begin
            n_rem = DW'(n_shift - {1'b0, r_dsr});
        end else begin
            n_rem = n_shift[DW-1:0];
        end
        n_quo = {r_quo[NW-2:0], n_bit};
    end

    // Load on start, step NW times, pulse done
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_rem  <= '0;
                r_quo  <= i_dividend;
                r_dsr  <= i_divisor;
                r_cnt  <= CW'(NW);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_quo <= n_quo;
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_stat.done     = r_done;
    assign o_stat.zero_rem = (r_rem == '0);
    assign o_quotient      = r_quo;

endmodule

>>> design/distinct_prime_factors.sv
// Distinct prime factors by trial division: 2, then odd divisors, up to the square root.
// Each trial divisor costs one run of the shared divider on VW bits, VW = min(VALUE_WIDTH,
// 32); a repeated factor adds one run per extra power. One value is handled at a time.
// Results leave one per strobe cycle, ascending; the receiver cannot stall them.
// Reset is synchronous, active low, and clears the sequencer and the strobe.
module distinct_prime_factors #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] i_value,
    output logic        o_strobe,
    output logic [31:0] o_factor,
    output logic        o_empty_res,
    output logic        o_last
);

    localparam int FW = dpf_pkg::FIELD_WIDTH;
    localparam int NW = (VALUE_WIDTH < FW) ? VALUE_WIDTH : FW;
    localparam int DW = NW / 2 + 2;
    localparam int SW = NW + 2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_CHECK,
        S_DIV,
        S_FINAL,
        S_LAST
    } t_state;

    t_state             r_state;
    logic [NW-1:0]      r_n;
    logic [DW-1:0]      r_d;
    logic [SW-1:0]      r_sq;
    logic               r_hit;
    logic [NW-1:0]      r_pend;
    logic               r_have_pend;
    logic               r_div_start;
    logic               r_strobe;
    logic [FW-1:0]      r_factor;
    logic               r_empty;
    logic               r_last;

    dpf_pkg::t_div_req  div_req;
    dpf_pkg::t_div_stat div_stat;
    logic [NW-1:0]      div_quo;

    assign div_req.start = r_div_start;

    dpf_div #(
        .NW (NW),
        .DW (DW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (div_req),
        .i_dividend (r_n),
        .i_divisor  (r_d),
        .o_stat     (div_stat),
        .o_quotient (div_quo)
    );

    // Sequencer: trial divisor, its square, pending factor and the result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_div_start <= 1'b0;
            r_strobe    <= 1'b0;
            r_have_pend <= 1'b0;
            r_hit       <= 1'b0;
        end else begin
            r_div_start <= 1'b0;
            r_strobe    <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_n         <= i_value[NW-1:0];
                        r_d         <= DW'(dpf_pkg::FIRST_PRIME);
                        r_sq        <= SW'(dpf_pkg::FIRST_PRIME * dpf_pkg::FIRST_PRIME);
                        r_hit       <= 1'b0;
                        r_have_pend <= 1'b0;
                        r_state     <= S_START;
                    end
                end
                S_START: begin
                    // Values below two have no prime factors
                    if (r_n < NW'(dpf_pkg::FIRST_PRIME)) begin
                        r_strobe <= 1'b1;
                        r_factor <= '0;
                        r_empty  <= 1'b1;
                        r_last   <= 1'b1;
                        r_state  <= S_IDLE;
                    end else begin
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    if (r_sq <= SW'(r_n)) begin
                        r_div_start <= 1'b1;
                        r_state     <= S_DIV;
                    end else begin
                        r_state <= S_FINAL;
                    end
                end
                S_DIV: begin
                    if (div_stat.done) begin
                        if (div_stat.zero_rem) begin
                            // Divides: strip this power and try again
                            r_n         <= div_quo;
                            r_hit       <= 1'b1;
                            r_div_start <= 1'b1;
                        end else begin
                            // Done with this divisor; hold its factor, release the older one
                            if (r_hit) begin
                                if (r_have_pend) begin
                                    r_strobe <= 1'b1;
                                    r_factor <= FW'(r_pend);
                                    r_empty  <= 1'b0;
                                    r_last   <= 1'b0;
                                end
                                r_pend      <= NW'(r_d);
                                r_have_pend <= 1'b1;
                            end
                            r_hit <= 1'b0;
                            if (r_d == DW'(dpf_pkg::FIRST_PRIME)) begin
                                r_d  <= DW'(dpf_pkg::SECOND_PRIME);
                                r_sq <= SW'(dpf_pkg::SECOND_PRIME * dpf_pkg::SECOND_PRIME);
                            end else begin
                                // (d+2)^2 = d^2 + 4d + 4
                                r_d  <= r_d + DW'(2);
                                r_sq <= r_sq + (SW'(r_d) << 2) + SW'(4);
                            end
                            r_state <= S_CHECK;
                        end
                    end
                end
                S_FINAL: begin
                    // A cofactor above one is prime and is the largest factor
                    if (r_n > NW'(1)) begin
                        if (r_have_pend) begin
                            r_strobe <= 1'b1;
                            r_factor <= FW'(r_pend);
                            r_empty  <= 1'b0;
                            r_last   <= 1'b0;
                        end
                        r_pend      <= r_n;
                        r_have_pend <= 1'b1;
                        r_state     <= S_LAST;
                    end else begin
                        r_strobe <= 1'b1;
                        r_factor <= FW'(r_pend);
                        r_empty  <= 1'b0;
                        r_last   <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                S_LAST: begin
                    r_strobe <= 1'b1;
                    r_factor <= FW'(r_pend);
                    r_empty  <= 1'b0;
                    r_last   <= 1'b1;
                    r_state  <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy        = (r_state != S_IDLE);
    assign o_strobe    = r_strobe;
    assign o_factor    = r_factor;
    assign o_empty_res = r_empty;
    assign o_last      = r_last;

endmodule
